@@ hdl/apr_pkg.sv @@
// Package for the ATA PIO request sequencer: widths, codes, actions and state types.
// No dependencies.
package apr_pkg;

   localparam int QUEUE_DEPTH_DEF = 8;
   localparam int BURST_MAX_DEF   = 256;

   localparam int LBA_W   = 28;
   localparam int COUNT_W = 29;
   localparam int TAG_W   = 8;
   localparam int CSR_W   = 29;
   localparam int CSR_IDX_W = 1;

   localparam logic [CSR_IDX_W-1:0] CSR_DRIVE_IS_SLAVE = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CAPACITY       = 1'd1;

   localparam logic [2:0] ACT_REG = 3'd0;
   localparam logic [2:0] ACT_RD  = 3'd1;
   localparam logic [2:0] ACT_WR  = 3'd2;
   localparam logic [2:0] ACT_REP = 3'd3;
   localparam logic [2:0] ACT_NC  = 3'd4;

   localparam logic [2:0] RC_DONE   = 3'd0;
   localparam logic [2:0] RC_IOERR  = 3'd1;
   localparam logic [2:0] RC_RANGE  = 3'd2;
   localparam logic [2:0] RC_UNSUP  = 3'd3;
   localparam logic [2:0] RC_FULL   = 3'd4;

   localparam logic [2:0] TF_NONE   = 3'd0;
   localparam logic [2:0] TF_COUNT  = 3'd2;
   localparam logic [2:0] TF_SECTOR = 3'd3;
   localparam logic [2:0] TF_CYL_LO = 3'd4;
   localparam logic [2:0] TF_CYL_HI = 3'd5;
   localparam logic [2:0] TF_DRVHD  = 3'd6;
   localparam logic [2:0] TF_CMD    = 3'd7;

   localparam logic [7:0] DH_BASE  = 8'hE0;
   localparam logic [7:0] DH_SLAVE = 8'h10;
   localparam logic [7:0] CMD_RD   = 8'h20;
   localparam logic [7:0] CMD_WR   = 8'h30;
   localparam int ST_BSY = 7;
   localparam int ST_DRQ = 3;
   localparam int ST_ERR = 0;

   typedef struct packed {
      logic              operation;
      logic [1:0]        req_kind;
      logic [LBA_W-1:0]  req_lba;
      logic [COUNT_W-1:0] req_count;
      logic [TAG_W-1:0]  req_tag;
      logic [7:0]        drive_status;
   } req_type;

   typedef struct packed {
      logic [2:0]       action;
      logic [2:0]       reg_addr;
      logic [7:0]       reg_value;
      logic [TAG_W-1:0] out_tag;
      logic [LBA_W-1:0] sector_index;
      logic [2:0]       result_code;
      logic             last;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_RDWAIT, ST_DECIDE, ST_BURST, ST_ENDREQ, ST_ENDRD, ST_EMIT
   } state_type;

endpackage

@@ hdl/apr_stream_if.sv @@
// Valid/ready channel carrying one payload type per beat.
// Depends on apr_pkg only through the type handed in.
interface apr_stream_if #(parameter type payload_type = logic) ();
   logic        valid;
   logic        ready;
   payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

@@ hdl/apr_queue_mem.sv @@
// Request queue storage: one synchronous memory, one write and one read port.
// Depends on apr_pkg.
module apr_queue_mem #(
   parameter int QUEUE_DEPTH = apr_pkg::QUEUE_DEPTH_DEF,
   localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1,
   localparam int DW = apr_pkg::LBA_W + apr_pkg::COUNT_W + 1 + apr_pkg::TAG_W
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [DW-1:0] wr_data,
   input  logic [AW-1:0] rd_addr,
   output logic [DW-1:0] rd_data
);
   logic [DW-1:0] mem [QUEUE_DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

@@ hdl/apr_out_fifo.sv @@
// Small result buffer that decouples the sequencer from the result channel.
// Depends on apr_pkg.
module apr_out_fifo (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  apr_pkg::rsp_type  push_data,
   output logic              can_push,
   output logic              empty,
   apr_stream_if.source      rsp
);
   apr_pkg::rsp_type buf_ff [2];
   logic [1:0] cnt_ff, cnt_in;
   logic rd_ff, wr_ff;
   logic pop;

   assign pop      = rsp.valid && rsp.ready;
   assign rsp.valid = (cnt_ff != 2'd0);
   assign rsp.payload = buf_ff[rd_ff];
   assign can_push = (cnt_ff != 2'd2);
   assign empty    = (cnt_ff == 2'd0);
   assign cnt_in   = cnt_ff + {1'b0, push} - {1'b0, pop};

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         rd_ff  <= 1'b0;
         wr_ff  <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         if (pop) rd_ff <= ~rd_ff;
         if (push) wr_ff <= ~wr_ff;
      end
      if (push) buf_ff[wr_ff] <= push_data;
   end

   assert property (@(posedge clock) disable iff (reset) !(push && cnt_ff == 2'd2))
      else $error("result buffer overflow");
endmodule

@@ hdl/ata_pio_request_sequencer_top.sv @@
// ATA PIO LBA28 request sequencer, top level.
// Throughput: at most one result beat per cycle; an input holds the block through the queue
// read, the serial emission and the draining of the result buffer; a request queued behind
// others goes straight back to idle.
// Reset (synchronous, active high) empties the queue and clears progress and config.
module ata_pio_request_sequencer_top #(
   parameter int QUEUE_DEPTH = apr_pkg::QUEUE_DEPTH_DEF,
   parameter int BURST_MAX   = apr_pkg::BURST_MAX_DEF
) (
   input  logic clock,
   input  logic reset,
   apr_stream_if.sink   req_if,
   apr_stream_if.source rsp_if,
   input  logic                          csr_we,
   input  logic [apr_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [apr_pkg::CSR_W-1:0]     csr_wdata
);
   localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int FW = $clog2(QUEUE_DEPTH + 1);
   localparam int DW = apr_pkg::LBA_W + apr_pkg::COUNT_W + 1 + apr_pkg::TAG_W;
   localparam int BW = $clog2(BURST_MAX + 1);
   localparam logic [FW-1:0] DEPTH_C = FW'(QUEUE_DEPTH);
   localparam logic [BW-1:0] BMAX_C  = BW'(BURST_MAX);

   // Configuration registers.
   logic                        slave_ff;
   logic [apr_pkg::COUNT_W-1:0] cap_ff;

   // Control state.
   apr_pkg::state_type state_ff, state_in;
   logic [AW-1:0] head_ff, head_in;
   logic [FW-1:0] fill_ff, fill_in;
   logic [apr_pkg::COUNT_W-1:0] prog_ff, prog_in;
   logic [BW-1:0] brem_ff, brem_in;
   apr_pkg::req_type in_ff, in_in;

   // Results of one input are built in a small script, then streamed out.
   apr_pkg::rsp_type scr_ff [12];
   apr_pkg::rsp_type scr_in [12];
   logic [3:0] scnt_ff, scnt_in, sptr_ff, sptr_in;

   // Head entry as read from the memory.
   logic [DW-1:0] rd_data;
   logic [AW-1:0] rd_addr;
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic [DW-1:0] wr_data;
   logic [apr_pkg::LBA_W-1:0]   h_lba;
   logic [apr_pkg::COUNT_W-1:0] h_cnt;
   logic                        h_wr;
   logic [apr_pkg::TAG_W-1:0]   h_tag;
   logic [7:0] dh;

   logic push, can_push, fifo_empty;
   apr_pkg::rsp_type push_data;

   assign {h_lba, h_cnt, h_wr, h_tag} = rd_data;
   assign dh = apr_pkg::DH_BASE | (slave_ff ? apr_pkg::DH_SLAVE : 8'h00);
   // A new beat is taken only once the previous input has fully left the block.
   assign req_if.ready = (state_ff == apr_pkg::ST_IDLE) && fifo_empty;

   apr_queue_mem #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_mem (
      .clock, .wr_en, .wr_addr, .wr_data, .rd_addr, .rd_data
   );

   apr_out_fifo u_fifo (
      .clock, .reset, .push, .push_data, .can_push, .empty(fifo_empty), .rsp(rsp_if)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         slave_ff <= 1'b0;
         cap_ff   <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            apr_pkg::CSR_DRIVE_IS_SLAVE: slave_ff <= csr_wdata[0];
            apr_pkg::CSR_CAPACITY:       cap_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= apr_pkg::ST_IDLE;
         head_ff  <= '0;
         fill_ff  <= '0;
         prog_ff  <= '0;
         brem_ff  <= '0;
         scnt_ff  <= '0;
         sptr_ff  <= '0;
      end else begin
         state_ff <= state_in;
         head_ff  <= head_in;
         fill_ff  <= fill_in;
         prog_ff  <= prog_in;
         brem_ff  <= brem_in;
         scnt_ff  <= scnt_in;
         sptr_ff  <= sptr_in;
      end
      in_ff  <= in_in;
      scr_ff <= scr_in;
   end

   // Helper to build a result item.
   function automatic apr_pkg::rsp_type mk(input logic [2:0] act, input logic [2:0] ad,
         input logic [7:0] v, input logic [7:0] t, input logic [27:0] s, input logic [2:0] c);
      apr_pkg::rsp_type r;
      r.action = act; r.reg_addr = ad; r.reg_value = v; r.out_tag = t;
      r.sector_index = s; r.result_code = c; r.last = 1'b0;
      return r;
   endfunction

   logic [apr_pkg::COUNT_W:0]   sum_w;
   logic [apr_pkg::COUNT_W-1:0] rem_w;
   logic [BW-1:0]               burst_w;
   logic [apr_pkg::LBA_W-1:0]   lba_w;
   logic [apr_pkg::COUNT_W-1:0] prog_nx;
   logic [FW:0]                 slot_sum;
   logic [AW-1:0]               slot_w;
   logic [AW-1:0]               head_nx;

   always_comb begin
      state_in = state_ff;
      head_in  = head_ff;
      fill_in  = fill_ff;
      prog_in  = prog_ff;
      brem_in  = brem_ff;
      scnt_in  = scnt_ff;
      sptr_in  = sptr_ff;
      in_in    = in_ff;
      scr_in   = scr_ff;
      rd_addr  = head_ff;
      wr_en    = 1'b0;
      wr_addr  = '0;
      wr_data  = '0;
      push     = 1'b0;
      push_data = scr_ff[sptr_ff];
      sum_w   = {1'b0, req_if.payload.req_count} +
                (apr_pkg::COUNT_W+1)'(req_if.payload.req_lba);
      rem_w   = (h_cnt > prog_ff) ? h_cnt - prog_ff : '0;
      burst_w = (rem_w > apr_pkg::COUNT_W'(BURST_MAX)) ? BMAX_C : BW'(rem_w);
      lba_w   = h_lba + prog_ff[apr_pkg::LBA_W-1:0];
      prog_nx = prog_ff + 1'b1;
      // Head and fill are both below or at the depth, so one subtraction wraps the slot.
      slot_sum = (FW+1)'(head_ff) + (FW+1)'(fill_ff);
      slot_w   = (slot_sum >= (FW+1)'(QUEUE_DEPTH)) ? AW'(slot_sum - (FW+1)'(QUEUE_DEPTH))
                                                     : AW'(slot_sum);
      head_nx  = (head_ff == AW'(QUEUE_DEPTH - 1)) ? '0 : head_ff + 1'b1;

      unique case (state_ff)
         apr_pkg::ST_IDLE: begin
            scnt_in = '0;
            sptr_in = '0;
            if (req_if.valid && req_if.ready) begin
               in_in = req_if.payload;
               if (req_if.payload.operation) begin
                  if (fill_ff == '0) begin
                     scr_in[0] = mk(apr_pkg::ACT_NC, apr_pkg::TF_NONE, 8'd0, 8'd0, '0,
                                    apr_pkg::RC_DONE);
                     scnt_in = 4'd1;
                     state_in = apr_pkg::ST_EMIT;
                  end else begin
                     state_in = apr_pkg::ST_RDWAIT;
                  end
               end else begin
                  state_in = apr_pkg::ST_EMIT;
                  scnt_in  = 4'd1;
                  if (sum_w > {1'b0, cap_ff})
                     scr_in[0] = mk(apr_pkg::ACT_REP, apr_pkg::TF_NONE, 8'd0,
                                    req_if.payload.req_tag, '0, apr_pkg::RC_RANGE);
                  else if (req_if.payload.req_kind[1])
                     scr_in[0] = mk(apr_pkg::ACT_REP, apr_pkg::TF_NONE, 8'd0,
                                    req_if.payload.req_tag, '0, apr_pkg::RC_UNSUP);
                  else if (fill_ff >= DEPTH_C)
                     scr_in[0] = mk(apr_pkg::ACT_REP, apr_pkg::TF_NONE, 8'd0,
                                    req_if.payload.req_tag, '0, apr_pkg::RC_FULL);
                  else if (req_if.payload.req_count == '0)
                     scr_in[0] = mk(apr_pkg::ACT_REP, apr_pkg::TF_NONE, 8'd0,
                                    req_if.payload.req_tag, '0, apr_pkg::RC_DONE);
                  else begin
                     wr_en   = 1'b1;
                     wr_addr = slot_w;
                     wr_data = {req_if.payload.req_lba, req_if.payload.req_count,
                                req_if.payload.req_kind[0], req_if.payload.req_tag};
                     fill_in = fill_ff + 1'b1;
                     scnt_in = '0;
                     if (fill_ff == '0) begin
                        prog_in  = '0;
                        state_in = apr_pkg::ST_RDWAIT;
                     end else begin
                        state_in = apr_pkg::ST_IDLE;
                     end
                  end
               end
            end
         end
         // The head entry (possibly written last cycle) is being read; its data is
         // available from the next cycle on.
         apr_pkg::ST_RDWAIT: begin
            state_in = in_ff.operation ? apr_pkg::ST_DECIDE : apr_pkg::ST_BURST;
         end
         apr_pkg::ST_DECIDE: begin
            scr_in[0] = mk(apr_pkg::ACT_REG, apr_pkg::TF_DRVHD, dh, h_tag, '0,
                           apr_pkg::RC_DONE);
            if (h_wr ? in_ff.drive_status[apr_pkg::ST_BSY]
                     : !(in_ff.drive_status[apr_pkg::ST_ERR] ||
                         in_ff.drive_status[apr_pkg::ST_DRQ])) begin
               scr_in[1] = mk(apr_pkg::ACT_NC, apr_pkg::TF_NONE, 8'd0, h_tag, '0,
                              apr_pkg::RC_DONE);
               scnt_in  = 4'd2;
               state_in = apr_pkg::ST_EMIT;
            end else if (in_ff.drive_status[apr_pkg::ST_ERR]) begin
               scr_in[1] = mk(apr_pkg::ACT_REP, apr_pkg::TF_NONE, 8'd0, h_tag,
                              prog_ff[apr_pkg::LBA_W-1:0], apr_pkg::RC_IOERR);
               scnt_in  = 4'd2;
               state_in = apr_pkg::ST_ENDREQ;
            end else begin
               scnt_in = 4'd1;
               if (!h_wr) begin
                  scr_in[1] = mk(apr_pkg::ACT_RD, apr_pkg::TF_NONE, 8'd0, h_tag,
                                 prog_ff[apr_pkg::LBA_W-1:0], apr_pkg::RC_DONE);
                  scnt_in = 4'd2;
               end
               scr_in[scnt_in] = mk(apr_pkg::ACT_REP, apr_pkg::TF_NONE, 8'd0, h_tag,
                                    prog_ff[apr_pkg::LBA_W-1:0], apr_pkg::RC_DONE);
               scnt_in = scnt_in + 1'b1;
               prog_in = prog_nx;
               if (brem_ff != '0) brem_in = brem_ff - 1'b1;
               if (prog_nx >= h_cnt) begin
                  state_in = apr_pkg::ST_ENDREQ;
               end else if (brem_in != '0) begin
                  if (h_wr) begin
                     scr_in[scnt_in] = mk(apr_pkg::ACT_WR, apr_pkg::TF_NONE, 8'd0, h_tag,
                                          prog_nx[apr_pkg::LBA_W-1:0], apr_pkg::RC_DONE);
                     scnt_in = scnt_in + 1'b1;
                  end
                  state_in = apr_pkg::ST_EMIT;
               end else begin
                  state_in = apr_pkg::ST_BURST;
               end
            end
         end
         apr_pkg::ST_ENDREQ: begin
            head_in = head_nx;
            if (fill_ff != '0) fill_in = fill_ff - 1'b1;
            prog_in = '0;
            brem_in = '0;
            if (fill_in != '0) begin
               state_in = apr_pkg::ST_ENDRD;
            end else begin
               scr_in[scnt_ff] = mk(apr_pkg::ACT_REG, apr_pkg::TF_DRVHD,
                                    (dh ^ apr_pkg::DH_SLAVE) & apr_pkg::DH_SLAVE, h_tag, '0,
                                    apr_pkg::RC_DONE);
               scnt_in  = scnt_ff + 1'b1;
               state_in = apr_pkg::ST_EMIT;
            end
         end
         apr_pkg::ST_ENDRD: begin
            state_in = apr_pkg::ST_BURST;
         end
         apr_pkg::ST_BURST: begin
            brem_in = burst_w;
            scr_in[scnt_ff] = mk(apr_pkg::ACT_REG, apr_pkg::TF_DRVHD,
                                 dh | {4'd0, lba_w[27:24]}, h_tag, '0, apr_pkg::RC_DONE);
            scr_in[scnt_ff+4'd1] = mk(apr_pkg::ACT_REG, apr_pkg::TF_CYL_HI, lba_w[23:16],
                                      h_tag, '0, apr_pkg::RC_DONE);
            scr_in[scnt_ff+4'd2] = mk(apr_pkg::ACT_REG, apr_pkg::TF_CYL_LO, lba_w[15:8],
                                      h_tag, '0, apr_pkg::RC_DONE);
            scr_in[scnt_ff+4'd3] = mk(apr_pkg::ACT_REG, apr_pkg::TF_SECTOR, lba_w[7:0],
                                      h_tag, '0, apr_pkg::RC_DONE);
            scr_in[scnt_ff+4'd4] = mk(apr_pkg::ACT_REG, apr_pkg::TF_COUNT,
                                      8'(burst_w), h_tag, '0, apr_pkg::RC_DONE);
            scr_in[scnt_ff+4'd5] = mk(apr_pkg::ACT_REG, apr_pkg::TF_CMD,
                                      h_wr ? apr_pkg::CMD_WR : apr_pkg::CMD_RD, h_tag, '0,
                                      apr_pkg::RC_DONE);
            scnt_in = scnt_ff + 4'd6;
            if (h_wr) begin
               scr_in[scnt_ff+4'd6] = mk(apr_pkg::ACT_WR, apr_pkg::TF_NONE, 8'd0, h_tag,
                                         prog_ff[apr_pkg::LBA_W-1:0], apr_pkg::RC_DONE);
               scnt_in = scnt_ff + 4'd7;
            end
            state_in = apr_pkg::ST_EMIT;
         end
         apr_pkg::ST_EMIT: begin
            push_data = scr_ff[sptr_ff];
            push_data.last = (sptr_ff + 1'b1 == scnt_ff);
            if (can_push) begin
               push    = 1'b1;
               sptr_in = sptr_ff + 1'b1;
               if (sptr_ff + 1'b1 == scnt_ff) state_in = apr_pkg::ST_IDLE;
            end
         end
         default: state_in = apr_pkg::ST_IDLE;
      endcase
   end

   assert property (@(posedge clock) disable iff (reset) fill_ff <= DEPTH_C)
      else $error("queue fill beyond depth");
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == apr_pkg::ST_EMIT) |-> (scnt_ff != '0 && sptr_ff < scnt_ff))
      else $error("emission pointer out of range");
   assert property (@(posedge clock) disable iff (reset)
      push |-> (state_ff == apr_pkg::ST_EMIT))
      else $error("result pushed outside emission");
   assert property (@(posedge clock) disable iff (reset) brem_ff <= BMAX_C)
      else $error("burst count beyond maximum");
endmodule

@@ sim/tb.sv @@
// Self-checking testbench for the ATA PIO LBA28 request sequencer.
// Depends on apr_pkg, apr_stream_if and ata_pio_request_sequencer_top.
`timescale 1ns / 100ps

module tb;

   localparam int NUM_RANDOM = 240;
   localparam int WATCHDOG_LIMIT = 20000;
   localparam int DRAIN_CYCLES = 40;
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int QD = apr_pkg::QUEUE_DEPTH_DEF;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   logic [apr_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [apr_pkg::CSR_W-1:0] csr_wdata = '0;

   always #1 clock = ~clock;

   apr_stream_if #(.payload_type(apr_pkg::req_type)) req_if ();
   apr_stream_if #(.payload_type(apr_pkg::rsp_type)) rsp_if ();

   ata_pio_request_sequencer_top u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_if.sink),
      .rsp_if    (rsp_if.source),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Predictor state: our own picture of the queue, progress and settings.
   logic                        slave_sel;
   logic [apr_pkg::COUNT_W-1:0] capacity;
   logic [apr_pkg::LBA_W-1:0]   q_lba [QD];
   logic [apr_pkg::COUNT_W-1:0] q_count [QD];
   logic                        q_write [QD];
   logic [apr_pkg::TAG_W-1:0]   q_tag [QD];
   int unsigned                 q_head;
   int unsigned                 q_fill;
   logic [apr_pkg::COUNT_W-1:0] progress;
   int unsigned                 burst_left;

   apr_pkg::req_type pending_reqs[$];
   apr_pkg::rsp_type expected_beats[$];
   int       mismatches = 0;
   int       idle_cycles = 0;
   bit       hold_rsp = 1'b0;

   function automatic logic [7:0] drive_head();
      return apr_pkg::DH_BASE | (slave_sel ? apr_pkg::DH_SLAVE : 8'h00);
   endfunction

   task automatic push_beat(input logic [2:0] act, input logic [2:0] addr,
                            input logic [7:0] val, input logic [apr_pkg::TAG_W-1:0] tag,
                            input logic [apr_pkg::LBA_W-1:0] sect, input logic [2:0] code);
      apr_pkg::rsp_type b;
      b.action = act; b.reg_addr = addr; b.reg_value = val; b.out_tag = tag;
      b.sector_index = sect; b.result_code = code; b.last = 1'b0;
      expected_beats.push_back(b);
   endtask

   task automatic issue_burst();
      int unsigned h;
      logic [apr_pkg::COUNT_W-1:0] rem;
      int unsigned len;
      logic [apr_pkg::LBA_W-1:0] lba;
      h = q_head;
      rem = (q_count[h] > progress) ? q_count[h] - progress : '0;
      len = (rem > apr_pkg::BURST_MAX_DEF) ? apr_pkg::BURST_MAX_DEF : rem;
      burst_left = len;
      lba = q_lba[h] + progress[apr_pkg::LBA_W-1:0];
      push_beat(apr_pkg::ACT_REG, apr_pkg::TF_DRVHD, drive_head() | {4'h0, lba[27:24]},
                q_tag[h], '0, apr_pkg::RC_DONE);
      push_beat(apr_pkg::ACT_REG, apr_pkg::TF_CYL_HI, lba[23:16], q_tag[h], '0,
                apr_pkg::RC_DONE);
      push_beat(apr_pkg::ACT_REG, apr_pkg::TF_CYL_LO, lba[15:8], q_tag[h], '0,
                apr_pkg::RC_DONE);
      push_beat(apr_pkg::ACT_REG, apr_pkg::TF_SECTOR, lba[7:0], q_tag[h], '0,
                apr_pkg::RC_DONE);
      push_beat(apr_pkg::ACT_REG, apr_pkg::TF_COUNT, len[7:0], q_tag[h], '0,
                apr_pkg::RC_DONE);
      push_beat(apr_pkg::ACT_REG, apr_pkg::TF_CMD,
                q_write[h] ? apr_pkg::CMD_WR : apr_pkg::CMD_RD, q_tag[h], '0,
                apr_pkg::RC_DONE);
      if (q_write[h])
         push_beat(apr_pkg::ACT_WR, apr_pkg::TF_NONE, 8'd0, q_tag[h],
                   progress[apr_pkg::LBA_W-1:0], apr_pkg::RC_DONE);
   endtask

   task automatic retire_request(input logic [apr_pkg::TAG_W-1:0] tag);
      q_head = (q_head + 1) % QD;
      if (q_fill > 0) q_fill--;
      progress = '0;
      burst_left = 0;
      if (q_fill > 0)
         issue_burst();
      else
         push_beat(apr_pkg::ACT_REG, apr_pkg::TF_DRVHD,
                   (drive_head() ^ apr_pkg::DH_SLAVE) & apr_pkg::DH_SLAVE, tag, '0,
                   apr_pkg::RC_DONE);
   endtask

   // Works out every beat that one accepted request or interrupt should cause.
   task automatic predict_sequencer(input apr_pkg::req_type r);
      int unsigned first;
      int unsigned h;
      int unsigned slot;
      logic [apr_pkg::TAG_W-1:0] tag;
      logic wr;
      logic [apr_pkg::COUNT_W-1:0] done;
      logic claimed;
      first = expected_beats.size();
      if (!r.operation) begin
         if ({1'b0, r.req_lba} + {1'b0, r.req_count} > {1'b0, capacity})
            push_beat(apr_pkg::ACT_REP, apr_pkg::TF_NONE, 8'd0, r.req_tag, '0,
                      apr_pkg::RC_RANGE);
         else if (r.req_kind > 2'd1)
            push_beat(apr_pkg::ACT_REP, apr_pkg::TF_NONE, 8'd0, r.req_tag, '0,
                      apr_pkg::RC_UNSUP);
         else if (q_fill >= QD)
            push_beat(apr_pkg::ACT_REP, apr_pkg::TF_NONE, 8'd0, r.req_tag, '0,
                      apr_pkg::RC_FULL);
         else if (r.req_count == '0)
            push_beat(apr_pkg::ACT_REP, apr_pkg::TF_NONE, 8'd0, r.req_tag, '0,
                      apr_pkg::RC_DONE);
         else begin
            slot = (q_head + q_fill) % QD;
            q_lba[slot] = r.req_lba;
            q_count[slot] = r.req_count;
            q_write[slot] = r.req_kind[0];
            q_tag[slot] = r.req_tag;
            q_fill++;
            if (q_fill == 1) begin
               progress = '0;
               issue_burst();
            end
         end
      end else if (q_fill == 0) begin
         push_beat(apr_pkg::ACT_NC, apr_pkg::TF_NONE, 8'd0, '0, '0, apr_pkg::RC_DONE);
      end else begin
         h = q_head;
         tag = q_tag[h];
         wr = q_write[h];
         push_beat(apr_pkg::ACT_REG, apr_pkg::TF_DRVHD, drive_head(), tag, '0,
                   apr_pkg::RC_DONE);
         claimed = wr ? !r.drive_status[apr_pkg::ST_BSY]
                      : (r.drive_status[apr_pkg::ST_ERR] || r.drive_status[apr_pkg::ST_DRQ]);
         if (!claimed)
            push_beat(apr_pkg::ACT_NC, apr_pkg::TF_NONE, 8'd0, tag, '0, apr_pkg::RC_DONE);
         else if (r.drive_status[apr_pkg::ST_ERR]) begin
            push_beat(apr_pkg::ACT_REP, apr_pkg::TF_NONE, 8'd0, tag,
                      progress[apr_pkg::LBA_W-1:0], apr_pkg::RC_IOERR);
            retire_request(tag);
         end else begin
            if (!wr)
               push_beat(apr_pkg::ACT_RD, apr_pkg::TF_NONE, 8'd0, tag,
                         progress[apr_pkg::LBA_W-1:0], apr_pkg::RC_DONE);
            done = progress;
            progress = progress + 1'b1;
            if (burst_left > 0) burst_left--;
            push_beat(apr_pkg::ACT_REP, apr_pkg::TF_NONE, 8'd0, tag,
                      done[apr_pkg::LBA_W-1:0], apr_pkg::RC_DONE);
            if (progress >= q_count[h])
               retire_request(tag);
            else if (burst_left > 0) begin
               if (wr)
                  push_beat(apr_pkg::ACT_WR, apr_pkg::TF_NONE, 8'd0, tag,
                            progress[apr_pkg::LBA_W-1:0], apr_pkg::RC_DONE);
            end else
               issue_burst();
         end
      end
      if (expected_beats.size() > first)
         expected_beats[expected_beats.size() - 1].last = 1'b1;
   endtask

   task automatic report_mismatch(input string what, input apr_pkg::rsp_type got,
                                  input apr_pkg::rsp_type want);
      $display("MISMATCH %s: got %p expected %p", what, got, want);
      mismatches++;
   endtask

   // Whether the beat on offer was taken at the last rising edge.
   bit req_taken = 1'b0;
   always @(posedge clock) req_taken <= req_if.valid && req_if.ready;

   // Driver: takes items from the pending queue, with a random gap before each beat.
   int send_gap = 0;
   always @(negedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
      end else if (req_if.valid && !req_taken) begin
         // Beat still on offer; hold it.
      end else if (send_gap > 0) begin
         req_if.valid <= 1'b0;
         send_gap <= send_gap - 1;
      end else if (pending_reqs.size() > 0) begin
         req_if.payload <= pending_reqs.pop_front();
         req_if.valid <= 1'b1;
         send_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
      end else begin
         req_if.valid <= 1'b0;
      end
   end

   // Receiver readiness: random stalls, plus a long hold-off when asked.
   int rsp_gap = 0;
   always @(negedge clock) begin
      if (reset || hold_rsp) begin
         rsp_if.ready <= 1'b0;
      end else if (rsp_gap > 0) begin
         rsp_if.ready <= 1'b0;
         rsp_gap <= rsp_gap - 1;
      end else begin
         rsp_if.ready <= 1'b1;
         if (rsp_if.valid)
            rsp_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
      end
   end

   // Monitor: predicts on every accepted request beat and checks every result beat.
   always @(posedge clock) begin
      apr_pkg::rsp_type want;
      if (!reset) begin
         if (req_if.valid && req_if.ready) begin
            predict_sequencer(req_if.payload);
            idle_cycles <= 0;
         end else if (rsp_if.valid && rsp_if.ready)
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
         if (rsp_if.valid && rsp_if.ready) begin
            if (expected_beats.size() == 0) begin
               want = '0;
               report_mismatch("unexpected beat", rsp_if.payload, want);
            end else begin
               want = expected_beats.pop_front();
               if (rsp_if.payload.action !== want.action)
                  report_mismatch("action", rsp_if.payload, want);
               else if (rsp_if.payload.reg_addr !== want.reg_addr)
                  report_mismatch("reg_addr", rsp_if.payload, want);
               else if (rsp_if.payload.reg_value !== want.reg_value)
                  report_mismatch("reg_value", rsp_if.payload, want);
               else if (rsp_if.payload.out_tag !== want.out_tag)
                  report_mismatch("out_tag", rsp_if.payload, want);
               else if (rsp_if.payload.sector_index !== want.sector_index)
                  report_mismatch("sector_index", rsp_if.payload, want);
               else if (rsp_if.payload.result_code !== want.result_code)
                  report_mismatch("result_code", rsp_if.payload, want);
               else if (rsp_if.payload.last !== want.last)
                  report_mismatch("last", rsp_if.payload, want);
            end
         end
      end
   end

   // Watchdog: the run is abandoned when nothing moves for too long.
   always @(posedge clock) begin
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   function automatic apr_pkg::req_type make_submit(input logic [1:0] kind,
                                                    input logic [apr_pkg::LBA_W-1:0] lba,
                                                    input logic [apr_pkg::COUNT_W-1:0] count,
                                                    input logic [apr_pkg::TAG_W-1:0] tag);
      apr_pkg::req_type r;
      r = '0;
      r.operation = 1'b0; r.req_kind = kind; r.req_lba = lba;
      r.req_count = count; r.req_tag = tag;
      r.drive_status = 8'($urandom);
      return r;
   endfunction

   function automatic apr_pkg::req_type make_irq(input logic [7:0] status);
      apr_pkg::req_type r;
      r = '0;
      r.operation = 1'b1;
      r.drive_status = status;
      r.req_kind = 2'($urandom);
      r.req_lba = 28'($urandom);
      r.req_count = 29'($urandom);
      r.req_tag = 8'($urandom);
      return r;
   endfunction

   // A good interrupt status: mostly a clean sector, now and then an error or a refusal.
   function automatic logic [7:0] pick_status();
      logic [7:0] s;
      int unsigned pick;
      s = 8'($urandom);
      pick = $urandom_range(0, 9);
      if (pick < 7) begin
         s[apr_pkg::ST_ERR] = 1'b0; s[apr_pkg::ST_BSY] = 1'b0; s[apr_pkg::ST_DRQ] = 1'b1;
      end else if (pick == 7)
         s[apr_pkg::ST_ERR] = 1'b1;
      return s;
   endfunction

   task automatic write_csr(input logic [apr_pkg::CSR_IDX_W-1:0] idx,
                            input logic [apr_pkg::CSR_W-1:0] val);
      @(negedge clock);
      csr_we <= 1'b1; csr_index <= idx; csr_wdata <= val;
      @(negedge clock);
      csr_we <= 1'b0;
      if (idx == apr_pkg::CSR_DRIVE_IS_SLAVE) slave_sel = val[0];
      else capacity = val;
   endtask

   // Waits until every queued item has gone in and every expected beat has come out.
   task automatic wait_quiet();
      while (pending_reqs.size() > 0 || req_if.valid || expected_beats.size() > 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   initial begin
      int unsigned n;
      int unsigned phase;
      logic [apr_pkg::COUNT_W-1:0] cnt;
      logic [apr_pkg::LBA_W-1:0] lba;
      req_if.valid = 1'b0;
      req_if.payload = '0;
      rsp_if.ready = 1'b0;
      slave_sel = 1'b0; capacity = '0;
      q_head = 0; q_fill = 0; progress = '0; burst_left = 0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // With zero capacity every non-empty request is out of range.
      pending_reqs.push_back(make_irq(8'hFF));
      pending_reqs.push_back(make_submit(2'd0, 28'hFFFFFFF, 29'h1FFFFFFF, 8'hFF));
      pending_reqs.push_back(make_submit(2'd0, 28'd0, 29'd0, 8'h00));
      wait_quiet();

      write_csr(apr_pkg::CSR_CAPACITY, 29'h10000000);
      write_csr(apr_pkg::CSR_DRIVE_IS_SLAVE, 1'b1);
      // Directed: each kind, the unsupported kinds, a range edge, queue overflow,
      // a burst boundary, unclaimed interrupts and an error.
      pending_reqs.push_back(make_submit(2'd2, 28'd0, 29'd1, 8'h12));
      pending_reqs.push_back(make_submit(2'd3, 28'd0, 29'd1, 8'h13));
      pending_reqs.push_back(make_submit(2'd0, 28'hFFFFFFF, 29'd2, 8'h14));
      pending_reqs.push_back(make_submit(2'd0, 28'hFFFFFFF, 29'd1, 8'hA5));
      pending_reqs.push_back(make_submit(2'd1, 28'h0000000, 29'd258, 8'h5A));
      for (int i = 0; i < 8; i++)
         pending_reqs.push_back(make_submit(2'(i % 2), 28'($urandom), 29'd2, 8'(i)));
      pending_reqs.push_back(make_irq(8'h00));
      pending_reqs.push_back(make_irq(8'h08));
      pending_reqs.push_back(make_irq(8'h01));
      pending_reqs.push_back(make_irq(8'h80));
      pending_reqs.push_back(make_irq(8'h00));
      for (int i = 0; i < 5; i++)
         pending_reqs.push_back(make_irq(8'h08));
      wait_quiet();

      // Drain whatever directed requests remain, one good sector at a time.
      while (q_fill > 0) begin
         pending_reqs.push_back(make_irq(8'h08));
         wait_quiet();
      end

      // Random phases with differing settings; sizes stay small apart from a rare long run or a rare random count.
      n = 0;
      phase = 0;
      while (n < NUM_RANDOM) begin
         write_csr(apr_pkg::CSR_DRIVE_IS_SLAVE, 1'($urandom));
         case (phase % 3)
            0: write_csr(apr_pkg::CSR_CAPACITY, 29'h10000000);
            1: write_csr(apr_pkg::CSR_CAPACITY, 29'($urandom_range(0, 4000)));
            default: write_csr(apr_pkg::CSR_CAPACITY, 29'($urandom));
         endcase
         if (phase == 1) hold_rsp = 1'b1;
         for (int i = 0; i < 40; i++) begin
            if ($urandom_range(0, 2) == 0) begin
               cnt = ($urandom_range(0, 30) == 0) ? 29'($urandom_range(250, 300))
                   : ($urandom_range(0, 15) == 0) ? 29'($urandom)
                   : 29'($urandom_range(0, 4));
               lba = ($urandom_range(0, 1) == 0) ? 28'($urandom_range(0, 3000))
                   : 28'($urandom);
               pending_reqs.push_back(make_submit(
                  ($urandom_range(0, 9) == 0) ? 2'($urandom_range(2, 3))
                                              : 2'($urandom_range(0, 1)),
                  lba, cnt, 8'($urandom)));
            end else
               pending_reqs.push_back(make_irq(pick_status()));
            n++;
         end
         if (phase == 1) begin
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
            hold_rsp = 1'b0;
         end
         wait_quiet();
         phase++;
      end

      // Finish off any request still active so the queue ends empty.
      while (q_fill > 0) begin
         pending_reqs.push_back(make_irq(8'h01));
         wait_quiet();
      end

      if (mismatches == 0 && expected_beats.size() == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
